/* hdl/mwh_pkg.sv */
// shared constants and helpers for the multimode word hash
`timescale 1ns / 1ps

package mwh_pkg;

  localparam int TAIL_REGION_DEF = 24;
  localparam int HASH_W = 18;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 3;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // hash kind codes
  localparam logic [KIND_W-1:0] KIND_16 = 3'd0;
  localparam logic [KIND_W-1:0] KIND_18 = 3'd1;
  localparam logic [KIND_W-1:0] KIND_15 = 3'd2;
  localparam logic [KIND_W-1:0] KIND_14 = 3'd3;
  localparam logic [KIND_W-1:0] KIND_12 = 3'd4;

  // register select bit (byte address bit 2)
  localparam logic REG_HASH_KIND = 1'b0;
  localparam logic REG_TAIL_MODE = 1'b1;

  localparam logic [HASH_W-1:0] MASK_16 = 18'o0177777;
  localparam logic [HASH_W-1:0] MASK_18 = 18'h3ffff;
  localparam logic [HASH_W-1:0] MASK_15 = 18'o077777;
  localparam logic [HASH_W-1:0] MASK_14 = 18'h3fff;
  localparam logic [HASH_W-1:0] MASK_12 = 18'o07777;

  // codes above the 12-bit kind fall back to the 16-bit kind
  function automatic logic [KIND_W-1:0] eff_kind(input logic [KIND_W-1:0] k);
    logic [KIND_W-1:0] r;
    r = (k > KIND_12) ? KIND_16 : k;
    return r;
  endfunction

  function automatic logic [HASH_W-1:0] kind_mask(input logic [KIND_W-1:0] k);
    logic [HASH_W-1:0] m;
    case (k)
      KIND_18: m = MASK_18;
      KIND_15: m = MASK_15;
      KIND_14: m = MASK_14;
      KIND_12: m = MASK_12;
      default: m = MASK_16;
    endcase
    return m;
  endfunction

  function automatic logic [HASH_W-1:0] sext8(input logic [CHAR_W-1:0] b);
    logic [HASH_W-1:0] r;
    r = {{(HASH_W-CHAR_W){b[CHAR_W-1]}}, b};
    return r;
  endfunction

endpackage

/* hdl/multimode_word_hash.sv */
// multimode word hash: byte stream in, one hash per word out
//
// Bytes of a word arrive on the input channel (in_valid / in_stall), one per
// transaction, with last_char set on the final byte. On that byte one result
// transaction (word_hash, tail_used) is offered on out_valid / out_stall.
// Bytes without last_char produce nothing.
// An accepted byte sits in the input register and is folded into the word
// state when it leaves that register; a final byte also loads the result
// register, which raises out_valid. One byte per cycle is sustained while
// no final byte is held back; the throughput is set by the single state
// update stage. While a result waits in the output register, non-final
// bytes keep flowing; a further final byte holds in the input register and
// in_stall rises until the waiting result is taken. hash_kind and tail_mode
// must be written over the APB port only while no word is in flight; the
// block does not enforce this. Synchronous reset clears both registers,
// the running hash, window sum, byte count and all valid flags; no clearing
// pass is needed.
`timescale 1ns / 1ps

module multimode_word_hash #(
  parameter int TAIL_REGION = mwh_pkg::TAIL_REGION_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // byte channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mwh_pkg::CHAR_W-1:0]    char_code,
  input  logic                          last_char,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mwh_pkg::HASH_W-1:0]    word_hash,
  output logic                          tail_used,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwh_pkg::PADDR_W-1:0]   paddr,
  input  logic [mwh_pkg::PDATA_W-1:0]   pwdata,
  output logic [mwh_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int WINDOW_LEN = TAIL_REGION + 2;
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int HW = mwh_pkg::HASH_W;
  localparam int CW = mwh_pkg::CHAR_W;

  // configuration registers
  logic [mwh_pkg::KIND_W-1:0] hash_kind;
  logic                       tail_mode;

  // input register
  logic          s1_valid;
  logic [CW-1:0] s1_char;
  logic          s1_last;

  // word state
  logic [HW-1:0]    running_hash;
  logic [HW-1:0]    window_sum;
  logic [CNT_W-1:0] byte_count;
  logic [CW-1:0]    recent_bytes [WINDOW_LEN];

  logic [HW-1:0]    running_hash_next;
  logic [HW-1:0]    window_sum_next;
  logic [CNT_W-1:0] byte_count_next;

  logic                       out_free;
  logic                       proc;
  logic [mwh_pkg::KIND_W-1:0] kind;
  logic                       in_head;
  logic [2:0]                 shift_bits;
  logic [15:0]                tail_head;
  logic [HW-1:0]              tail_hash;
  logic                       tail_hit;
  logic [HW-1:0]              result;

  assign out_free = !out_valid || !out_stall;
  assign proc     = s1_valid && (!s1_last || out_free);
  assign in_stall = s1_valid && !proc;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_kind <= mwh_pkg::KIND_16;
      tail_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        mwh_pkg::REG_HASH_KIND: hash_kind <= pwdata[mwh_pkg::KIND_W-1:0];
        mwh_pkg::REG_TAIL_MODE: tail_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mwh_pkg::REG_HASH_KIND:
        prdata = {{(mwh_pkg::PDATA_W-mwh_pkg::KIND_W){1'b0}}, hash_kind};
      mwh_pkg::REG_TAIL_MODE:
        prdata = {{(mwh_pkg::PDATA_W-1){1'b0}}, tail_mode};
      default: prdata = '0;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_char <= char_code;
      s1_last <= last_char;
    end
  end

  // per-byte update
  always_comb begin
    kind = mwh_pkg::eff_kind(hash_kind);

    if (kind == mwh_pkg::KIND_15 || kind == mwh_pkg::KIND_14) begin
      in_head = byte_count < CNT_W'(3);
    end else begin
      in_head = byte_count < CNT_W'(4);
    end

    case (kind)
      mwh_pkg::KIND_18: shift_bits = byte_count[0] ? 3'd4 : 3'd5;
      mwh_pkg::KIND_15,
      mwh_pkg::KIND_14: shift_bits = 3'd5;
      mwh_pkg::KIND_12: shift_bits = 3'd3;
      default:          shift_bits = 3'd4;
    endcase

    if (in_head) begin
      case (shift_bits)
        3'd3:    running_hash_next = {running_hash[HW-4:0], s1_char[2:0]};
        3'd5:    running_hash_next = {running_hash[HW-6:0], s1_char[4:0]};
        default: running_hash_next = {running_hash[HW-5:0], s1_char[3:0]};
      endcase
    end else begin
      running_hash_next = running_hash + mwh_pkg::sext8(s1_char);
    end

    // sum over window positions 6 and beyond, kept as bytes slide through
    window_sum_next = window_sum;
    if (byte_count >= CNT_W'(6)) begin
      window_sum_next = window_sum_next + mwh_pkg::sext8(recent_bytes[5]);
    end
    if (byte_count == CNT_W'(WINDOW_LEN)) begin
      window_sum_next = window_sum_next - mwh_pkg::sext8(recent_bytes[WINDOW_LEN-1]);
    end

    if (byte_count == CNT_W'(WINDOW_LEN)) begin
      byte_count_next = byte_count;
    end else begin
      byte_count_next = byte_count + CNT_W'(1);
    end

    // bytes 3 to 6 from the end sit in slots 1 to 4 before the shift
    if (kind == mwh_pkg::KIND_12) begin
      tail_head = {4'd0, recent_bytes[1][2:0], recent_bytes[2][2:0],
                   recent_bytes[3][2:0], recent_bytes[4][2:0]};
    end else begin
      tail_head = {recent_bytes[1][3:0], recent_bytes[2][3:0],
                   recent_bytes[3][3:0], recent_bytes[4][3:0]};
    end
    tail_hash = HW'(tail_head) + window_sum_next;

    tail_hit = tail_mode && (kind == mwh_pkg::KIND_16 || kind == mwh_pkg::KIND_12)
               && (byte_count_next == CNT_W'(WINDOW_LEN));

    result = (tail_hit ? tail_hash : running_hash_next) & mwh_pkg::kind_mask(kind);
  end

  // word state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      window_sum   <= '0;
      byte_count   <= '0;
    end else if (proc) begin
      if (s1_last) begin
        running_hash <= '0;
        window_sum   <= '0;
        byte_count   <= '0;
      end else begin
        running_hash <= running_hash_next;
        window_sum   <= window_sum_next;
        byte_count   <= byte_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      recent_bytes[0] <= s1_char;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        recent_bytes[i] <= recent_bytes[i-1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s1_last) begin
      word_hash <= result;
      tail_used <= tail_hit;
    end
  end

  // checks
  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (proc && s1_last) |=> (byte_count == '0 && running_hash == '0))
    else $error("word state not cleared after final byte");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(WINDOW_LEN))
    else $error("byte count beyond window length");

  a_window_empty: assert property (@(posedge clk) disable iff (rst)
    (byte_count < CNT_W'(7)) |-> (window_sum == '0))
    else $error("window sum holds bytes before window filled");

  a_final_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && out_valid && out_stall) |-> in_stall)
    else $error("final byte taken while result still waiting");

endmodule

/* sim/tb_multimode_word_hash.sv */
`timescale 1ns / 1ps
// testbench for multimode_word_hash: directed word table, then random words checked by a predictor
module tb_multimode_word_hash;

  localparam int HASH_W = mwh_pkg::HASH_W;
  localparam int CHAR_W = mwh_pkg::CHAR_W;
  localparam int KIND_W = mwh_pkg::KIND_W;
  localparam int PADDR_W = mwh_pkg::PADDR_W;
  localparam int PDATA_W = mwh_pkg::PDATA_W;
  localparam int WINDOW = mwh_pkg::TAIL_REGION_DEF + 2;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 630;
  localparam int BACKLOG_HOLD = 80;
  localparam int SETTLE = 4;
  localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;
  localparam logic [PADDR_W-1:0] ADDR_KIND = {mwh_pkg::REG_HASH_KIND, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_TAIL = {mwh_pkg::REG_TAIL_MODE, 2'b00};

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              from_tail;
  } hash_rec_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              tail;
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              known;
    logic [HASH_W-1:0] hash;
    logic              from_tail;
  } word_row_t;

  logic clk, rst;
  logic in_valid, in_stall, last_char;
  logic [CHAR_W-1:0] char_code;
  logic out_valid, out_stall, tail_used;
  logic [HASH_W-1:0] word_hash;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  // predictor state and its copy of the registers
  logic [KIND_W-1:0] cfg_kind;
  logic cfg_tail;
  logic [HASH_W-1:0] word_sum;
  int word_len;
  logic [CHAR_W-1:0] byte_hist [WINDOW];

  hash_rec_t pending_hashes [$];
  int mismatches = 0;
  int idle_cycles = 0;
  int hold_len = 0;
  bit no_idle = 1'b0;

  word_row_t word_rows [24] = '{
    // straight after reset: one byte, low nibble only
    '{mwh_pkg::KIND_16, 1'b0, 8'hff, 1'b1, 1'b1, 18'h0000f, 1'b0},
    '{mwh_pkg::KIND_16, 1'b0, 8'h0f, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_16, 1'b0, 8'h0f, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_16, 1'b0, 8'h0f, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_16, 1'b0, 8'h0f, 1'b1, 1'b1, 18'h0ffff, 1'b0},
    '{mwh_pkg::KIND_18, 1'b0, 8'h1f, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_18, 1'b0, 8'h0f, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_18, 1'b0, 8'h1f, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_18, 1'b0, 8'h0f, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_18, 1'b0, 8'h7f, 1'b1, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_15, 1'b0, 8'hff, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_15, 1'b0, 8'hff, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_15, 1'b0, 8'hff, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_15, 1'b0, 8'h80, 1'b1, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_14, 1'b0, 8'h00, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_14, 1'b0, 8'h00, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_14, 1'b0, 8'h01, 1'b1, 1'b1, 18'h00001, 1'b0},
    // short word in tail mode falls back to the head rule
    '{mwh_pkg::KIND_12, 1'b1, 8'h07, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_12, 1'b1, 8'h07, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_12, 1'b1, 8'h07, 1'b0, 1'b0, 18'h0, 1'b0},
    '{mwh_pkg::KIND_12, 1'b1, 8'h07, 1'b1, 1'b1, 18'h00fff, 1'b0},
    '{KIND_SPARE, 1'b1, 8'h55, 1'b0, 1'b0, 18'h0, 1'b0},
    '{KIND_SPARE, 1'b1, 8'haa, 1'b1, 1'b0, 18'h0, 1'b0},
    // tail mode has no effect on the 18-bit kind
    '{mwh_pkg::KIND_18, 1'b1, 8'h80, 1'b1, 1'b1, 18'h00000, 1'b0}
  };

  multimode_word_hash uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic fold_byte(input logic [CHAR_W-1:0] c, input logic fin,
                           output bit emits, output hash_rec_t rec);
    logic [KIND_W-1:0] k;
    int head_n, sh, width;
    logic [HASH_W-1:0] mask, tsum;
    k = cfg_kind;
    // spare codes behave as the 16-bit kind
    if (k > mwh_pkg::KIND_12) k = mwh_pkg::KIND_16;
    case (k)
      mwh_pkg::KIND_18: begin
        head_n = 4; width = 18; sh = word_len[0] ? 4 : 5;
      end
      mwh_pkg::KIND_15: begin
        head_n = 3; width = 15; sh = 5;
      end
      mwh_pkg::KIND_14: begin
        head_n = 3; width = 14; sh = 5;
      end
      mwh_pkg::KIND_12: begin
        head_n = 4; width = 12; sh = 3;
      end
      default: begin
        head_n = 4; width = 16; sh = 4;
      end
    endcase
    if (word_len < head_n)
      word_sum = (word_sum << sh) | HASH_W'(c & ((1 << sh) - 1));
    else
      word_sum = word_sum + {{(HASH_W-CHAR_W){c[CHAR_W-1]}}, c};
    for (int i = WINDOW - 1; i > 0; i--) byte_hist[i] = byte_hist[i-1];
    byte_hist[0] = c;
    if (word_len < WINDOW) word_len++;
    emits = fin;
    rec = '0;
    if (fin) begin
      mask = HASH_W'((1 << width) - 1);
      rec.hash = word_sum & mask;
      if (cfg_tail && (k == mwh_pkg::KIND_16 || k == mwh_pkg::KIND_12)
          && word_len >= WINDOW) begin
        // suffix region: bytes 3..6 from the end shifted in, the rest added
        tsum = '0;
        for (int i = 2; i <= 5; i++)
          tsum = (tsum << sh) | HASH_W'(byte_hist[i] & ((1 << sh) - 1));
        for (int i = 6; i < WINDOW; i++)
          tsum = tsum + {{(HASH_W-CHAR_W){byte_hist[i][CHAR_W-1]}}, byte_hist[i]};
        rec.hash = tsum & mask;
        rec.from_tail = 1'b1;
      end
      word_sum = '0;
      word_len = 0;
    end
  endtask

  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic fin,
                           input logic typed, input hash_rec_t typed_rec);
    int gap;
    bit emits;
    hash_rec_t rec;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    last_char <= fin;
    do @(posedge clk); while (in_stall !== 1'b0);
    fold_byte(c, fin, emits, rec);
    if (emits) pending_hashes.push_back(typed ? typed_rec : rec);
  endtask

  // leaves psel and penable high; the caller closes the access
  task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
  endtask

  task automatic set_config(input logic [KIND_W-1:0] k, input logic t);
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    apb_write(ADDR_KIND, PDATA_W'(k));
    apb_write(ADDR_TAIL, PDATA_W'(t));
    psel <= 1'b0;
    penable <= 1'b0;
    cfg_kind = k;
    cfg_tail = t;
  endtask

  initial begin : result_sink
    int n;
    out_stall <= 1'b1;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      // long hold-off so the input side backs up
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      n = no_idle ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : check_results
    hash_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_hashes.size() == 0) begin
        $error("unexpected transaction: word_hash %h tail_used %b", word_hash, tail_used);
        mismatches++;
      end else begin
        want = pending_hashes.pop_front();
        if (word_hash !== want.hash) begin
          $error("word_hash: expected %h, got %h", want.hash, word_hash);
          mismatches++;
        end
        if (tail_used !== want.from_tail) begin
          $error("tail_used: expected %b, got %b", want.from_tail, tail_used);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("multimode_word_hash verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int sent, phase, nwords, len;
    logic [KIND_W-1:0] k;
    logic t;
    bit open;
    in_valid <= 1'b0;
    char_code <= '0;
    last_char <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst <= 1'b1;
    cfg_kind = mwh_pkg::KIND_16;
    cfg_tail = 1'b0;
    word_sum = '0;
    word_len = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    open = 1'b0;
    foreach (word_rows[r]) begin
      if (!open && (word_rows[r].kind != cfg_kind || word_rows[r].tail != cfg_tail))
        set_config(word_rows[r].kind, word_rows[r].tail);
      send_byte(word_rows[r].code, word_rows[r].last, word_rows[r].known,
                {word_rows[r].hash, word_rows[r].from_tail});
      open = !word_rows[r].last;
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        k = mwh_pkg::KIND_16; t = 1'b1;
      end else if (phase == 1) begin
        k = mwh_pkg::KIND_12; t = 1'b1;
      end else begin
        k = KIND_W'($urandom_range(0, 7));
        t = 1'($urandom_range(0, 1));
      end
      set_config(k, t);
      no_idle = (phase % 4 == 3) || (phase == 2);
      if (phase == 2) hold_len = BACKLOG_HOLD;
      nwords = $urandom_range(3, 6);
      repeat (nwords) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: len = $urandom_range(1, 6);
          5, 6: len = $urandom_range(7, 25);
          default: len = $urandom_range(24, 34);
        endcase
        // short words during the backlog so final bytes pile up
        if (phase == 2) len = $urandom_range(1, 3);
        for (int j = 0; j < len; j++) begin
          send_byte(CHAR_W'($urandom_range(0, 255)), j == len - 1, 1'b0, '0);
          sent++;
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("multimode_word_hash verification clean");
    else
      $display("multimode_word_hash verification failed");
    $finish;
  end

endmodule

/* multimode_word_hash.f */
hdl/mwh_pkg.sv
hdl/multimode_word_hash.sv
sim/tb_multimode_word_hash.sv
